>>> rtl/joint_safety_supervisor_macros.svh
// Assertion macros for the joint safety supervisor.
// Define ASSERT_OFF to compile them away.
`ifndef JOINT_SAFETY_SUPERVISOR_MACROS_SVH
`define JOINT_SAFETY_SUPERVISOR_MACROS_SVH

`ifndef ASSERT_OFF
`define JSS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define JSS_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define JSS_ASSERT(lbl, clk, rst_n, prop, msg)
`define JSS_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif

`endif

>>> rtl/jss_pkg.sv
package jss_pkg;

	localparam int VALUE_BITS = 16;
	localparam int MAG_BITS   = VALUE_BITS - 1;
	localparam int JOINT_W    = 4;
	localparam int JOINT_SPAN = 1 << JOINT_W;
	localparam int OP_W       = 4;
	localparam int LIMIT_W    = 24;
	localparam int REG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	typedef enum logic [OP_W-1:0] {
		OP_TICK        = 4'd0,
		OP_FEED        = 4'd1,
		OP_INPUT_SEEN  = 4'd2,
		OP_CHECK       = 4'd3,
		OP_STOP        = 4'd4,
		OP_CLEAR_STOP  = 4'd5,
		OP_RESET       = 4'd6,
		OP_WRITE_LIMIT = 4'd7,
		OP_CLEAR_TABLE = 4'd8
	} op_t;

	typedef enum logic [2:0] {
		EV_NONE      = 3'd0,
		EV_STOP      = 3'd1,
		EV_VIOLATION = 3'd2,
		EV_STALE     = 3'd3,
		EV_WATCHDOG  = 3'd4
	} ev_t;

	localparam logic [REG_IDX_W-1:0] REG_ESTOP_ENABLE    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_WATCHDOG_ENABLE = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_WATCHDOG_LIMIT  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_INPUT_ENABLE    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_INPUT_LIMIT     = 3'd4;

	localparam logic [LIMIT_W-1:0] WATCHDOG_LIMIT_RST = 24'd1000;
	localparam logic [LIMIT_W-1:0] INPUT_LIMIT_RST    = 24'd500;

	typedef struct packed {
		logic [OP_W-1:0]               op;
		logic [JOINT_W-1:0]            joint;
		logic signed [VALUE_BITS-1:0]  position;
		logic signed [VALUE_BITS-1:0]  velocity;
		logic signed [VALUE_BITS-1:0]  effort;
		logic                          limit_on;
		logic signed [VALUE_BITS-1:0]  pos_min;
		logic signed [VALUE_BITS-1:0]  pos_max;
		logic [MAG_BITS-1:0]           vel_max;
		logic [MAG_BITS-1:0]           effort_max;
	} request_t;

	typedef struct packed {
		logic               joint_ok;
		logic               stop_active;
		logic               dog_expired;
		logic               input_stale;
		logic               limit_violated;
		logic [JOINT_W-1:0] bad_joint;
		logic [2:0]         event_kind;
		logic               event_raised;
	} result_t;

	typedef struct packed {
		logic                         on;
		logic signed [VALUE_BITS-1:0] pmin;
		logic signed [VALUE_BITS-1:0] pmax;
		logic [MAG_BITS-1:0]          vmax;
		logic [MAG_BITS-1:0]          emax;
	} limit_t;

	// classified request as queued between front and back
	typedef struct packed {
		logic [OP_W-1:0]              op;
		logic                         joint_hit;
		logic [JOINT_W-1:0]           joint;
		logic signed [VALUE_BITS-1:0] position;
		logic [VALUE_BITS-1:0]        vel_mag;
		logic [VALUE_BITS-1:0]        eff_mag;
		limit_t                       lim;
	} cmd_t;

endpackage

>>> rtl/jss_fifo.sv
module jss_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty,
	output logic             full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [CNT_W-1:0] count_q;
	logic             wr, rd;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign wr    = wr_en && !full;
	assign rd    = rd_en && !empty;
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/jss_front.sv
module jss_front import jss_pkg::*; #(
	parameter int JOINT_COUNT = 16
) (
	input  request_t request,
	output cmd_t     cmd
);

	// two's complement magnitude; the most negative value maps to 2^(n-1) unsigned
	function automatic logic [VALUE_BITS-1:0] abs_val(logic signed [VALUE_BITS-1:0] v);
		return v[VALUE_BITS-1] ? (~v + 1'b1) : v;
	endfunction

	always_comb begin
		cmd.op        = request.op;
		cmd.joint     = request.joint;
		cmd.joint_hit = (int'(request.joint) < JOINT_COUNT);
		cmd.position  = request.position;
		cmd.vel_mag   = abs_val(request.velocity);
		cmd.eff_mag   = abs_val(request.effort);
		cmd.lim.on    = request.limit_on;
		cmd.lim.pmin  = request.pos_min;
		cmd.lim.pmax  = request.pos_max;
		cmd.lim.vmax  = request.vel_max;
		cmd.lim.emax  = request.effort_max;
	end

endmodule

>>> rtl/jss_back.sv
module jss_back import jss_pkg::*; #(
	parameter int JOINT_COUNT = 16,
	parameter int TICK_BITS   = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [REG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  cmd_t                  cmd,
	input  logic                  cmd_empty,
	input  logic                  res_full,
	output logic                  cmd_pop,
	output logic                  res_push,
	output result_t               res
);

	localparam int TAB_DEPTH = (JOINT_COUNT < JOINT_SPAN) ? JOINT_COUNT : JOINT_SPAN;
	localparam int IDX_W     = (TAB_DEPTH > 1) ? $clog2(TAB_DEPTH) : 1;
	localparam int CMP_W     = (TICK_BITS > LIMIT_W) ? TICK_BITS : LIMIT_W;

	logic                 estop_en_q, dog_en_q, input_en_q;
	logic [LIMIT_W-1:0]   dog_limit_q, input_limit_q;

	logic [TAB_DEPTH-1:0] present_q;
	limit_t               entry_q [TAB_DEPTH];

	logic [TICK_BITS-1:0] dog_count_q, input_count_q;
	logic                 stop_q, dog_flag_q, stale_q, viol_q;
	logic [JOINT_W-1:0]   bad_q;
	ev_t                  event_q;

	logic                 go;
	logic [IDX_W-1:0]     idx;
	limit_t               entry;
	logic [TICK_BITS-1:0] dog_inc, input_inc;
	logic                 dog_hit, stale_hit, out_of_limits;

	logic [TICK_BITS-1:0] n_dog_count, n_input_count;
	logic                 n_stop, n_dog_flag, n_stale, n_viol;
	logic [JOINT_W-1:0]   n_bad;
	ev_t                  n_event;
	logic                 ok, raised;

	assign go       = !cmd_empty && !res_full;
	assign cmd_pop  = go;
	assign res_push = go;

	assign idx   = cmd.joint[IDX_W-1:0];
	assign entry = entry_q[idx];

	assign dog_inc   = (&dog_count_q) ? dog_count_q : dog_count_q + 1'b1;
	assign input_inc = (&input_count_q) ? input_count_q : input_count_q + 1'b1;
	assign stale_hit = input_en_q && (CMP_W'(input_inc) > CMP_W'(input_limit_q));
	assign dog_hit   = dog_en_q && (CMP_W'(dog_inc) > CMP_W'(dog_limit_q));

	assign out_of_limits = (cmd.position < entry.pmin) || (cmd.position > entry.pmax) ||
		(cmd.vel_mag > {1'b0, entry.vmax}) || (cmd.eff_mag > {1'b0, entry.emax});

	always_comb begin
		n_dog_count   = dog_count_q;
		n_input_count = input_count_q;
		n_stop        = stop_q;
		n_dog_flag    = dog_flag_q;
		n_stale       = stale_q;
		n_viol        = viol_q;
		n_bad         = bad_q;
		n_event       = event_q;
		ok            = 1'b0;
		raised        = 1'b0;
		case (cmd.op)
			OP_TICK: begin
				n_dog_count   = dog_inc;
				n_input_count = input_inc;
				if (stale_hit) begin
					n_stale = 1'b1;
					n_event = EV_STALE;
					raised  = 1'b1;
				end
				if (dog_hit) begin
					n_dog_flag = 1'b1;
					n_event    = EV_WATCHDOG;
					raised     = 1'b1;
					if (estop_en_q) begin
						n_stop  = 1'b1;
						n_event = EV_STOP;
					end
				end
				// on a tick with the emergency stop enabled, any latched fault escalates to a stop
				if (estop_en_q && (n_dog_flag || n_stale || viol_q) && !n_stop) begin
					n_stop  = 1'b1;
					n_event = EV_STOP;
					raised  = 1'b1;
				end
			end
			OP_FEED: begin
				n_dog_count = '0;
				n_dog_flag  = 1'b0;
			end
			OP_INPUT_SEEN: begin
				n_input_count = '0;
				n_stale       = 1'b0;
			end
			OP_CHECK: begin
				if (cmd.joint_hit && present_q[idx]) begin
					if (entry.on && out_of_limits) begin
						n_viol  = 1'b1;
						n_bad   = cmd.joint;
						n_event = EV_VIOLATION;
						raised  = 1'b1;
					end else begin
						ok = 1'b1;
					end
				end
			end
			OP_STOP: begin
				if (estop_en_q) begin
					n_stop  = 1'b1;
					n_event = EV_STOP;
					raised  = 1'b1;
				end
			end
			OP_CLEAR_STOP: begin
				n_stop = 1'b0;
			end
			OP_RESET: begin
				n_stop        = 1'b0;
				n_dog_flag    = 1'b0;
				n_stale       = 1'b0;
				n_viol        = 1'b0;
				n_bad         = '0;
				n_event       = EV_NONE;
				n_dog_count   = '0;
				n_input_count = '0;
			end
			OP_WRITE_LIMIT, OP_CLEAR_TABLE: begin
				// table updates only, see below
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res.joint_ok       = ok;
		res.stop_active    = n_stop;
		res.dog_expired    = n_dog_flag;
		res.input_stale    = n_stale;
		res.limit_violated = n_viol;
		res.bad_joint      = n_bad;
		res.event_kind     = n_event;
		res.event_raised   = raised;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dog_count_q   <= '0;
			input_count_q <= '0;
			stop_q        <= 1'b0;
			dog_flag_q    <= 1'b0;
			stale_q       <= 1'b0;
			viol_q        <= 1'b0;
			bad_q         <= '0;
			event_q       <= EV_NONE;
			present_q     <= '0;
		end else if (go) begin
			dog_count_q   <= n_dog_count;
			input_count_q <= n_input_count;
			stop_q        <= n_stop;
			dog_flag_q    <= n_dog_flag;
			stale_q       <= n_stale;
			viol_q        <= n_viol;
			bad_q         <= n_bad;
			event_q       <= n_event;
			if (cmd.op == OP_CLEAR_TABLE) begin
				present_q <= '0;
			end else if (cmd.op == OP_WRITE_LIMIT && cmd.joint_hit) begin
				present_q[idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && cmd.op == OP_WRITE_LIMIT && cmd.joint_hit) begin
			entry_q[idx] <= cmd.lim;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			estop_en_q    <= 1'b1;
			dog_en_q      <= 1'b1;
			dog_limit_q   <= WATCHDOG_LIMIT_RST;
			input_en_q    <= 1'b1;
			input_limit_q <= INPUT_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ESTOP_ENABLE:    estop_en_q    <= cfg_data[0];
				REG_WATCHDOG_ENABLE: dog_en_q      <= cfg_data[0];
				REG_WATCHDOG_LIMIT:  dog_limit_q   <= cfg_data[LIMIT_W-1:0];
				REG_INPUT_ENABLE:    input_en_q    <= cfg_data[0];
				REG_INPUT_LIMIT:     input_limit_q <= cfg_data[LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

>>> rtl/joint_safety_supervisor.sv
// Path: a request is registered in the command queue; the back end executes it from
// its head and registers the result in the result queue, waiting while that queue is full.
// Throughput: one request per cycle while the result queue is not full.
// Reset (arst_n low, asynchronous): flags, counters and event code cleared, registers
// at their defaults, all limit entries marked absent, both queues emptied.
`include "joint_safety_supervisor_macros.svh"

module joint_safety_supervisor import jss_pkg::*; #(
	parameter int JOINT_COUNT = 16,
	parameter int TICK_BITS   = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  request_t              request,
	output logic                  empty,
	input  logic                  pop,
	output result_t               result,
	input  logic                  cfg_we,
	input  logic [REG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CMD_DEPTH = 2;
	localparam int RES_DEPTH = 2;

	cmd_t                     cmd_in, cmd_out;
	logic [$bits(cmd_t)-1:0]  cmd_rdata;
	logic                     cmd_empty, cmd_pop;
	result_t                  res;
	logic [$bits(result_t)-1:0] res_rdata;
	logic                     res_full, res_push;

	jss_front #(
		.JOINT_COUNT(JOINT_COUNT)
	) u_front (
		.request(request),
		.cmd    (cmd_in)
	);

	jss_fifo #(
		.WIDTH($bits(cmd_t)),
		.DEPTH(CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (push),
		.wr_data(cmd_in),
		.rd_en  (cmd_pop),
		.rd_data(cmd_rdata),
		.empty  (cmd_empty),
		.full   (full)
	);

	assign cmd_out = cmd_t'(cmd_rdata);

	jss_back #(
		.JOINT_COUNT(JOINT_COUNT),
		.TICK_BITS  (TICK_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cmd      (cmd_out),
		.cmd_empty(cmd_empty),
		.res_full (res_full),
		.cmd_pop  (cmd_pop),
		.res_push (res_push),
		.res      (res)
	);

	jss_fifo #(
		.WIDTH($bits(result_t)),
		.DEPTH(RES_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_push),
		.wr_data(res),
		.rd_en  (pop),
		.rd_data(res_rdata),
		.empty  (empty),
		.full   (res_full)
	);

	assign result = result_t'(res_rdata);

	// an accepted request is always waiting for the back end on the next cycle
	`JSS_ASSERT_NEXT(a_req_queued, clk, arst_n, push && !full, !cmd_empty, "request lost")
	`JSS_ASSERT(a_stop_event, clk, arst_n, (!empty && result.event_raised && result.event_kind == EV_STOP) |-> result.stop_active, "stop event without stop flag")
	`JSS_ASSERT(a_dog_event, clk, arst_n, (!empty && result.event_raised && result.event_kind == EV_WATCHDOG) |-> result.dog_expired, "watchdog event without flag")
	`JSS_ASSERT(a_ok_quiet, clk, arst_n, (!empty && result.joint_ok) |-> !result.event_raised, "passing check raised an event")

endmodule

>>> tb/joint_safety_supervisor_tb.sv
`timescale 1ns / 1ps

module joint_safety_supervisor_tb;
	import jss_pkg::*;

	// op codes past the last defined one; the block must leave its state alone
	localparam logic [OP_W-1:0] OP_UNUSED_LO = 4'd9;
	localparam logic [OP_W-1:0] OP_UNUSED_HI = 4'd15;
	localparam int RUN_LIMIT_NS = 2_000_000;

	class supervisor_mirror;
		limit_t                 entry[JOINT_SPAN];
		bit                     present[JOINT_SPAN];
		bit [JOINT_SPAN-1:0]    written;
		logic [LIMIT_W-1:0]     dog_ticks, input_ticks, dog_limit, input_limit;
		bit                     estop_en, dog_en, input_en;
		bit                     stop, dog, stale, violation;
		logic [JOINT_W-1:0]     bad_joint;
		logic [2:0]             ev;
		result_t                expected_status[$];
		int                     errors;

		function new();
			foreach (present[i]) present[i] = 0;
			written = '0;
			dog_ticks = '0;
			input_ticks = '0;
			dog_limit = WATCHDOG_LIMIT_RST;
			input_limit = INPUT_LIMIT_RST;
			estop_en = 1;
			dog_en = 1;
			input_en = 1;
			stop = 0;
			dog = 0;
			stale = 0;
			violation = 0;
			bad_joint = '0;
			ev = EV_NONE;
			errors = 0;
		endfunction

		task report(string msg);
			$display("ERROR at %0t: %s", $time, msg);
			errors++;
		endtask

		function void set_register(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_ESTOP_ENABLE:    estop_en = data[0];
				REG_WATCHDOG_ENABLE: dog_en = data[0];
				REG_WATCHDOG_LIMIT:  dog_limit = data[LIMIT_W-1:0];
				REG_INPUT_ENABLE:    input_en = data[0];
				REG_INPUT_LIMIT:     input_limit = data[LIMIT_W-1:0];
				default: ;
			endcase
		endfunction

		function bit fire_stop();
			if (estop_en) begin
				stop = 1;
				ev = EV_STOP;
			end
			return estop_en;
		endfunction

		function void note_request(request_t r);
			result_t res;
			limit_t  lim;
			int      p, v, e;
			bit      ok, raised;
			ok = 0;
			raised = 0;
			case (r.op)
				OP_TICK: begin
					if (dog_ticks != '1) dog_ticks++;
					if (input_ticks != '1) input_ticks++;
					if (input_en && input_ticks > input_limit) begin
						stale = 1;
						ev = EV_STALE;
						raised = 1;
					end
					if (dog_en && dog_ticks > dog_limit) begin
						dog = 1;
						ev = EV_WATCHDOG;
						raised = 1;
						if (fire_stop()) raised = 1;
					end
					if (estop_en && (dog || stale || violation) && !stop)
						if (fire_stop()) raised = 1;
				end
				OP_FEED: begin
					dog_ticks = '0;
					dog = 0;
				end
				OP_INPUT_SEEN: begin
					input_ticks = '0;
					stale = 0;
				end
				OP_CHECK: begin
					if (present[r.joint]) begin
						lim = entry[r.joint];
						if (!lim.on) begin
							ok = 1;
						end else begin
							p = r.position;
							v = r.velocity;
							e = r.effort;
							if (v < 0) v = -v;
							if (e < 0) e = -e;
							ok = !(p < int'(lim.pmin) || p > int'(lim.pmax) ||
								v > int'(lim.vmax) || e > int'(lim.emax));
							if (!ok) begin
								violation = 1;
								bad_joint = r.joint;
								ev = EV_VIOLATION;
								raised = 1;
							end
						end
					end
				end
				OP_STOP: begin
					if (fire_stop()) raised = 1;
				end
				OP_CLEAR_STOP: stop = 0;
				OP_RESET: begin
					stop = 0;
					dog = 0;
					stale = 0;
					violation = 0;
					bad_joint = '0;
					ev = EV_NONE;
					dog_ticks = '0;
					input_ticks = '0;
				end
				OP_WRITE_LIMIT: begin
					present[r.joint] = 1;
					written[r.joint] = 1;
					entry[r.joint].on = r.limit_on;
					entry[r.joint].pmin = r.pos_min;
					entry[r.joint].pmax = r.pos_max;
					entry[r.joint].vmax = r.vel_max;
					entry[r.joint].emax = r.effort_max;
				end
				OP_CLEAR_TABLE: foreach (present[i]) present[i] = 0;
				default: ;
			endcase
			res.joint_ok = ok;
			res.stop_active = stop;
			res.dog_expired = dog;
			res.input_stale = stale;
			res.limit_violated = violation;
			res.bad_joint = bad_joint;
			res.event_kind = ev;
			res.event_raised = raised;
			expected_status.push_back(res);
		endfunction

		task cmp_field(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report($sformatf("%s got %0h expected %0h", name, got, want));
		endtask

		task check_result(result_t got);
			result_t want;
			if (expected_status.size() == 0) begin
				report("result with no request outstanding");
			end else begin
				want = expected_status.pop_front();
				cmp_field("joint_ok", 32'(got.joint_ok), 32'(want.joint_ok));
				cmp_field("stop_active", 32'(got.stop_active), 32'(want.stop_active));
				cmp_field("dog_expired", 32'(got.dog_expired), 32'(want.dog_expired));
				cmp_field("input_stale", 32'(got.input_stale), 32'(want.input_stale));
				cmp_field("limit_violated", 32'(got.limit_violated),
					32'(want.limit_violated));
				cmp_field("bad_joint", 32'(got.bad_joint), 32'(want.bad_joint));
				cmp_field("event_kind", 32'(got.event_kind), 32'(want.event_kind));
				cmp_field("event_raised", 32'(got.event_raised), 32'(want.event_raised));
			end
		endtask

		function int pending();
			return expected_status.size();
		endfunction
	endclass

	logic                  clk = 0;
	logic                  arst_n = 0;
	logic                  push = 0;
	logic                  full;
	request_t              request = '0;
	logic                  empty;
	logic                  pop = 0;
	result_t               result;
	logic                  cfg_we = 0;
	logic [REG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	supervisor_mirror mirror = new();
	int pop_hold = 0;
	bit no_gaps = 0;

	joint_safety_supervisor i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.request   (request),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	initial begin
		#RUN_LIMIT_NS;
		$display("Some tests failed");
		$finish;
	end

	function int pick_gap();
		int w;
		if (no_gaps) return 0;
		w = $urandom_range(0, 99);
		if (w < 55) return 0;
		if (w < 85) return $urandom_range(1, 3);
		if (w < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function logic [VALUE_BITS-1:0] near_mag(logic [MAG_BITS-1:0] top);
		int m;
		case ($urandom_range(0, 3))
			0: m = top;
			1: m = int'(top) + 1;
			2: m = $urandom_range(0, top);
			default: m = $urandom_range(0, 32768);
		endcase
		if ($urandom_range(0, 1)) m = -m;
		return m[VALUE_BITS-1:0];
	endfunction

	function logic [VALUE_BITS-1:0] near_pos(limit_t lim);
		int p;
		case ($urandom_range(0, 5))
			0: p = int'(lim.pmin) - 1;
			1: p = lim.pmin;
			2: p = lim.pmax;
			3: p = int'(lim.pmax) + 1;
			4: begin
				if (lim.pmin <= lim.pmax)
					p = int'(lim.pmin) + $urandom_range(0, int'(lim.pmax) - int'(lim.pmin));
				else
					p = lim.pmin;
			end
			default: p = $urandom_range(0, 65535);
		endcase
		return p[VALUE_BITS-1:0];
	endfunction

	function request_t blank(logic [OP_W-1:0] op, logic [JOINT_W-1:0] j);
		request_t r;
		r = '0;
		r.op = op;
		r.joint = j;
		return r;
	endfunction

	function request_t make_random();
		request_t     r;
		logic [127:0] raw;
		limit_t       lim;
		int           lo, hi, t, w;
		raw = {$urandom(), $urandom(), $urandom(), $urandom()};
		r = raw[$bits(request_t)-1:0];
		w = $urandom_range(0, 99);
		if (w < 30) r.op = OP_TICK;
		else if (w < 60) r.op = OP_CHECK;
		else if (w < 70) r.op = OP_WRITE_LIMIT;
		else if (w < 78) r.op = OP_FEED;
		else if (w < 86) r.op = OP_INPUT_SEEN;
		else if (w < 89) r.op = OP_STOP;
		else if (w < 93) r.op = OP_CLEAR_STOP;
		else if (w < 95) r.op = OP_RESET;
		else if (w < 97) r.op = OP_CLEAR_TABLE;
		else r.op = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
		// checks only go to entries whose contents have been written
		if (r.op == OP_CHECK) begin
			if (mirror.written == '0) begin
				r.op = OP_WRITE_LIMIT;
			end else begin
				while (!mirror.written[r.joint])
					r.joint = JOINT_W'($urandom_range(0, JOINT_SPAN - 1));
				if ($urandom_range(0, 9) < 7) begin
					lim = mirror.entry[r.joint];
					r.position = near_pos(lim);
					r.velocity = near_mag(lim.vmax);
					r.effort = near_mag(lim.emax);
				end
			end
		end
		if (r.op == OP_WRITE_LIMIT && $urandom_range(0, 9) < 8) begin
			lo = $urandom_range(0, 6000) - 3000;
			hi = lo + $urandom_range(0, 3000);
			if ($urandom_range(0, 9) == 0) begin
				t = lo;
				lo = hi;
				hi = t;
			end
			r.limit_on = ($urandom_range(0, 9) != 0);
			r.pos_min = lo[VALUE_BITS-1:0];
			r.pos_max = hi[VALUE_BITS-1:0];
			r.vel_max = MAG_BITS'($urandom_range(0, 3000));
			r.effort_max = MAG_BITS'($urandom_range(0, 3000));
		end
		return r;
	endfunction

	task send(request_t r);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk) push <= 0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		push <= 1;
		request <= r;
		@(posedge clk);
		while (full) @(posedge clk);
		mirror.note_request(r);
	endtask

	task write_register(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		mirror.set_register(idx, data);
	endtask

	task drain();
		@(negedge clk) push <= 0;
		while (mirror.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task configure(bit es, bit we, logic [LIMIT_W-1:0] wl, bit ie, logic [LIMIT_W-1:0] il);
		write_register(REG_ESTOP_ENABLE, CFG_DATA_W'(es));
		write_register(REG_WATCHDOG_ENABLE, CFG_DATA_W'(we));
		write_register(REG_WATCHDOG_LIMIT, wl);
		write_register(REG_INPUT_ENABLE, CFG_DATA_W'(ie));
		write_register(REG_INPUT_LIMIT, il);
		@(negedge clk) cfg_we <= 0;
	endtask

	task run_phase(bit es, bit we, logic [LIMIT_W-1:0] wl, bit ie, logic [LIMIT_W-1:0] il,
			int count);
		drain();
		configure(es, we, wl, ie, il);
		repeat (count) send(make_random());
	endtask

	task directed();
		request_t r;
		r = blank(OP_WRITE_LIMIT, 0);
		r.limit_on = 1;
		r.pos_min = -16'sd100;
		r.pos_max = 16'sd100;
		r.vel_max = 15'd50;
		r.effort_max = 15'd60;
		send(r);
		r = make_random();
		r.op = OP_WRITE_LIMIT;
		r.joint = 1;
		r.limit_on = 0;
		send(r);
		r = blank(OP_WRITE_LIMIT, 15);
		r.limit_on = 1;
		r.pos_min = 16'sh8000;
		r.pos_max = 16'sh7fff;
		r.vel_max = '1;
		r.effort_max = '1;
		send(r);
		// inclusive bounds pass
		r = blank(OP_CHECK, 0);
		r.position = 16'sd100;
		r.velocity = -16'sd50;
		r.effort = 16'sd60;
		send(r);
		r.position = -16'sd100;
		r.velocity = 16'sd50;
		r.effort = -16'sd60;
		send(r);
		// disabled entry passes whatever the values
		r = make_random();
		r.op = OP_CHECK;
		r.joint = 1;
		send(r);
		r = blank(OP_CHECK, 15);
		r.position = 16'sh8000;
		r.velocity = 16'sh7fff;
		r.effort = -16'sh7fff;
		send(r);
		// magnitude of the most negative value exceeds any limit
		r.velocity = 16'sh8000;
		send(r);
		r = blank(OP_CHECK, 0);
		r.position = -16'sd101;
		send(r);
		r.position = 16'sd101;
		send(r);
		r.position = 0;
		r.velocity = 16'sd51;
		send(r);
		r.velocity = 0;
		r.effort = -16'sd61;
		send(r);
		send(blank(OP_TICK, 0));
		send(blank(OP_CLEAR_STOP, 0));
		send(blank(OP_TICK, 0));
		send(blank(OP_TICK, 0));
		send(blank(OP_FEED, 0));
		send(blank(OP_INPUT_SEEN, 0));
		send(blank(OP_STOP, 0));
		send(blank(OP_RESET, 0));
		send(blank(OP_CLEAR_TABLE, 0));
		send(blank(OP_CHECK, 0));
		send(blank(OP_UNUSED_LO, 0));
		send(blank(OP_UNUSED_HI, 15));
		r = blank(OP_WRITE_LIMIT, 0);
		r.limit_on = 1;
		r.pos_min = -16'sd100;
		r.pos_max = 16'sd100;
		r.vel_max = 15'd50;
		r.effort_max = 15'd60;
		send(r);
	endtask

	// result side: random pop gaps plus an optional long hold-off
	initial begin
		int rx_gap;
		rx_gap = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (pop_hold > 0) begin
				pop_hold--;
				pop <= 0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				pop <= 0;
			end else begin
				pop <= 1;
			end
			@(posedge clk);
			if (pop && !empty) begin
				mirror.check_result(result);
				rx_gap = pick_gap();
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n <= 1;
		configure(1, 1, 24'd2, 1, 24'd1);
		directed();
		repeat (150) send(make_random());
		run_phase(0, 1, 24'd0, 1, 24'd0, 250);
		// back-to-back requests against a stalled result side
		no_gaps = 1;
		drain();
		configure(1, 0, '1, 0, '1);
		pop_hold = 400;
		repeat (250) send(make_random());
		no_gaps = 0;
		run_phase(1, 1, LIMIT_W'($urandom_range(3, 40)), 1, LIMIT_W'($urandom_range(3, 40)), 300);
		run_phase(0, 0, 24'd10, 1, 24'd20, 250);
		run_phase(1, 1, WATCHDOG_LIMIT_RST, 1, INPUT_LIMIT_RST, 150);
		run_phase(1, 1, 24'd5, 1, 24'd3, 150);
		drain();
		repeat (10) @(posedge clk);
		if (mirror.pending() != 0)
			mirror.report($sformatf("%0d results never arrived", mirror.pending()));
		if (mirror.errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
